// File: sv/autorange_voltmeter_display_core_defines.svh
// Assertion macros shared by the checker of the autoranging voltmeter display core.
// The macros expect signals named clk_i and rst_ni in the scope where they are used.
`ifndef AUTORANGE_VOLTMETER_DISPLAY_CORE_DEFINES_SVH
`define AUTORANGE_VOLTMETER_DISPLAY_CORE_DEFINES_SVH

// Property checked on every rising edge outside reset.
`define AVD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("avd checker: property violated");

// Consequent must hold in the cycle after the antecedent.
`define AVD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("avd checker: next-cycle property violated");

`endif

// File: sv/avd_pkg.sv
// Package of the autoranging voltmeter display core: types, constants, segment table.
// Used by every module of the block; depends on nothing.
package avd_pkg;

  localparam int unsigned SampleW  = 8;
  localparam int unsigned CountW   = 14;
  localparam int unsigned ProductW = SampleW + CountW;
  localparam int unsigned SegW     = 7;

  localparam logic [CountW-1:0] ReadingMax = 14'd9999;
  localparam logic [SampleW-1:0] SampleMax = 8'd255;

  // floor(2^30 / 255); the quotient estimate is exact or one below.
  localparam int unsigned RecipShift = 30;
  localparam logic [22:0] Recip255   = 23'd4210752;

  typedef enum logic [1:0] {
    CFG_LOW_THRESHOLD     = 2'd0,
    CFG_HIGH_THRESHOLD    = 2'd1,
    CFG_WIDE_FULL_SCALE   = 2'd2,
    CFG_NARROW_FULL_SCALE = 2'd3
  } avd_cfg_idx_e;

  typedef struct packed {
    logic [SampleW-1:0] low_threshold;
    logic [SampleW-1:0] high_threshold;
    logic [CountW-1:0]  wide_full_scale;
    logic [CountW-1:0]  narrow_full_scale;
  } avd_cfg_t;

  typedef struct packed {
    logic [ProductW-1:0] product;
    logic                narrow;
  } avd_entry_t;

  // Segment a is bit 0, segment g is bit 6.
  function automatic logic [SegW-1:0] seg_code(input logic [3:0] digit);
    logic [SegW-1:0] code;
    case (digit)
      4'd0:    code = 7'h3f;
      4'd1:    code = 7'h06;
      4'd2:    code = 7'h5b;
      4'd3:    code = 7'h4f;
      4'd4:    code = 7'h66;
      4'd5:    code = 7'h6d;
      4'd6:    code = 7'h7d;
      4'd7:    code = 7'h07;
      4'd8:    code = 7'h7f;
      4'd9:    code = 7'h6f;
      default: code = 7'h00;
    endcase
    return code;
  endfunction

endpackage

// File: sv/avd_queue.sv
// Small FIFO between the front and the back of the voltmeter display core.
// Holds avd_pkg::avd_entry_t items; depends on avd_pkg.
module avd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  avd_pkg::avd_entry_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output avd_pkg::avd_entry_t data_o,
  output logic                empty_o
);
  import avd_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  avd_entry_t          mem_q [DEPTH];
  logic [AW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]       count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: sv/avd_front.sv
// Front of the voltmeter display core: range decision and full-scale product.
// Keeps the range flag and feeds the queue; depends on avd_pkg.
module avd_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  avd_pkg::avd_cfg_t                cfg_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [avd_pkg::SampleW-1:0]      sample_i,
  input  logic                             queue_full_i,
  output logic                             push_o,
  output avd_pkg::avd_entry_t              entry_o
);
  import avd_pkg::*;

  logic               range_narrow_q, range_narrow_d;
  logic [CountW-1:0]  full_scale;

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && in_ready_o;

  // The range switches with hysteresis before the same sample is scaled.
  always_comb begin
    if (!range_narrow_q) begin
      range_narrow_d = (sample_i < cfg_i.low_threshold);
    end else begin
      range_narrow_d = !(sample_i > cfg_i.high_threshold);
    end
  end

  assign full_scale      = range_narrow_d ? cfg_i.narrow_full_scale : cfg_i.wide_full_scale;
  assign entry_o.product = ProductW'(sample_i) * ProductW'(full_scale);
  assign entry_o.narrow  = range_narrow_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_narrow_q <= 1'b0;
    end else if (push_o) begin
      range_narrow_q <= range_narrow_d;
    end
  end

endmodule

// File: sv/avd_back.sv
// Back of the voltmeter display core: divide by 255, saturate, split into digits.
// Four-stage pipeline that stalls as a whole on the output; depends on avd_pkg.
module avd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  avd_pkg::avd_entry_t         entry_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [avd_pkg::CountW-1:0]  reading_o,
  output logic [avd_pkg::SegW-1:0]    seg_thousands_o,
  output logic [avd_pkg::SegW-1:0]    seg_hundreds_o,
  output logic [avd_pkg::SegW-1:0]    seg_tens_o,
  output logic [avd_pkg::SegW-1:0]    seg_units_o,
  output logic                        point_position_o,
  output logic                        narrow_selected_o
);
  import avd_pkg::*;

  localparam int unsigned MulW = ProductW + 23;
  localparam int unsigned QW   = MulW - RecipShift;

  logic                v1_q, v2_q, v3_q, v4_q;
  logic                en;

  logic [MulW-1:0]     mul1;
  logic [ProductW-1:0] x1_q;
  logic [QW-1:0]       q1_q;
  logic                n1_q;

  logic [ProductW:0]   rem2;
  logic [QW-1:0]       quot2;
  logic [CountW-1:0]   reading2_q;
  logic                n2_q;

  logic [3:0]          th3;
  logic [9:0]          r3;
  logic [3:0]          th3_q;
  logic [9:0]          r3_q;
  logic [CountW-1:0]   reading3_q;
  logic                n3_q;

  logic [3:0]          hu4, te4, un4;
  logic [6:0]          r4;
  logic [CountW-1:0]   reading4_q;
  logic [SegW-1:0]     seg_th_q, seg_hu_q, seg_te_q, seg_un_q;
  logic                n4_q;

  assign en    = !v4_q || out_ready_i;
  assign pop_o = en && !empty_i;

  assign mul1 = MulW'(entry_i.product) * MulW'(Recip255);

  // The estimate is the quotient or one below; the remainder tells which.
  assign rem2  = (ProductW + 1)'(x1_q) - (ProductW + 1)'(q1_q) * (ProductW + 1)'(SampleMax);
  assign quot2 = q1_q + QW'(rem2 >= (ProductW + 1)'(SampleMax));

  always_comb begin
    th3 = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (reading2_q >= CountW'(k * 1000)) begin
        th3 = 4'(k);
      end
    end
    r3 = 10'(reading2_q - CountW'(th3) * CountW'(1000));
  end

  always_comb begin
    hu4 = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (r3_q >= 10'(k * 100)) begin
        hu4 = 4'(k);
      end
    end
    r4 = 7'(r3_q - 10'(hu4) * 10'(100));
    te4 = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (r4 >= 7'(k * 10)) begin
        te4 = 4'(k);
      end
    end
    un4 = 4'(r4 - 7'(te4) * 7'(10));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= !empty_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q       <= entry_i.product;
      q1_q       <= mul1[MulW-1:RecipShift];
      n1_q       <= entry_i.narrow;

      reading2_q <= (quot2 > QW'(ReadingMax)) ? ReadingMax : CountW'(quot2);
      n2_q       <= n1_q;

      th3_q      <= th3;
      r3_q       <= r3;
      reading3_q <= reading2_q;
      n3_q       <= n2_q;

      reading4_q <= reading3_q;
      seg_th_q   <= seg_code(th3_q);
      seg_hu_q   <= seg_code(hu4);
      seg_te_q   <= seg_code(te4);
      seg_un_q   <= seg_code(un4);
      n4_q       <= n3_q;
    end
  end

  assign out_valid_o       = v4_q;
  assign reading_o         = reading4_q;
  assign seg_thousands_o   = seg_th_q;
  assign seg_hundreds_o    = seg_hu_q;
  assign seg_tens_o        = seg_te_q;
  assign seg_units_o       = seg_un_q;
  assign point_position_o  = n4_q;
  assign narrow_selected_o = n4_q;

endmodule

// File: sv/autorange_voltmeter_display_core.sv
// Autoranging voltmeter display core: top level with configuration registers.
// Instantiates avd_front, avd_queue and avd_back; depends on avd_pkg.
//
// Usage:
//   Input channel (in_valid_i, in_ready_o, sample_i) takes one converter sample
//   per item. Output channel (out_valid_o, out_ready_i) returns one result item
//   per sample: reading, four seven-segment digits, point position, range flag.
//   Configuration is written through cfg_we_i, cfg_index_i and cfg_data_i while
//   no item is in flight; index 0 low threshold, 1 high threshold, 2 wide full
//   scale, 3 narrow full scale.
// Timing:
//   A sample accepted by the front passes the queue and the four back stages,
//   and its result waits until the output is free. One item per cycle is sustained
//   while out_ready_i is high; the first back stage holds a 22 by 23 bit reciprocal multiply.
// Reset:
//   The wide range is selected and the registers take 6, 254, 1000 and 5000.
// Stall:
//   When out_ready_i is low the back pipeline holds, the queue of QUEUE_DEPTH
//   entries fills, and in_ready_o drops once it is full.
module autorange_voltmeter_display_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [avd_pkg::CountW-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [avd_pkg::SampleW-1:0] sample_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [avd_pkg::CountW-1:0]  reading_o,
  output logic [avd_pkg::SegW-1:0]    seg_thousands_o,
  output logic [avd_pkg::SegW-1:0]    seg_hundreds_o,
  output logic [avd_pkg::SegW-1:0]    seg_tens_o,
  output logic [avd_pkg::SegW-1:0]    seg_units_o,
  output logic                        point_position_o,
  output logic                        narrow_selected_o
);
  import avd_pkg::*;

  avd_cfg_t   cfg_q;
  avd_entry_t push_entry, pop_entry;
  logic       push, pop, queue_full, queue_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_threshold     <= 8'd6;
      cfg_q.high_threshold    <= 8'd254;
      cfg_q.wide_full_scale   <= 14'd1000;
      cfg_q.narrow_full_scale <= 14'd5000;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LOW_THRESHOLD:     cfg_q.low_threshold     <= cfg_data_i[SampleW-1:0];
        CFG_HIGH_THRESHOLD:    cfg_q.high_threshold    <= cfg_data_i[SampleW-1:0];
        CFG_WIDE_FULL_SCALE:   cfg_q.wide_full_scale   <= cfg_data_i;
        CFG_NARROW_FULL_SCALE: cfg_q.narrow_full_scale <= cfg_data_i;
        default: ;
      endcase
    end
  end

  avd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  avd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (queue_full),
    .pop_i   (pop),
    .data_o  (pop_entry),
    .empty_o (queue_empty)
  );

  avd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .empty_i           (queue_empty),
    .entry_i           (pop_entry),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .reading_o         (reading_o),
    .seg_thousands_o   (seg_thousands_o),
    .seg_hundreds_o    (seg_hundreds_o),
    .seg_tens_o        (seg_tens_o),
    .seg_units_o       (seg_units_o),
    .point_position_o  (point_position_o),
    .narrow_selected_o (narrow_selected_o)
  );

endmodule

// File: sv/avd_checker.sv
// Port-level checker of the autoranging voltmeter display core, bound to the top.
// Depends on avd_pkg and the assertion macros of the defines header.
`include "autorange_voltmeter_display_core_defines.svh"

module avd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [avd_pkg::CountW-1:0]  reading_o,
  input logic [avd_pkg::SegW-1:0]    seg_units_o,
  input logic                        point_position_o,
  input logic                        narrow_selected_o
);
  import avd_pkg::*;

  // A result that waits must stay and keep its reading and units digit.
  `AVD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `AVD_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i,
                   $stable(reading_o) && $stable(seg_units_o))

  // The point follows the range, and the reading never leaves four digits.
  `AVD_ASSERT(a_point_range, out_valid_o |-> (point_position_o == narrow_selected_o))
  `AVD_ASSERT(a_reading_max, out_valid_o |-> (reading_o <= ReadingMax))

endmodule

bind autorange_voltmeter_display_core avd_checker u_avd_checker (.*);

// File: tb/tb_autorange_voltmeter_display_core.sv
// Self-checking testbench of the autoranging voltmeter display core.
// Drives samples and register writes, predicts every result item; uses avd_pkg.
module tb_autorange_voltmeter_display_core;
  timeunit 1ns;
  timeprecision 1ps;

  import avd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned ITEMS_PER_PHASE = 190;

  localparam logic [SegW-1:0] DIGIT_SEGS [10] = '{
    7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f
  };

  typedef struct packed {
    logic [CountW-1:0] reading;
    logic [SegW-1:0]   seg_thousands;
    logic [SegW-1:0]   seg_hundreds;
    logic [SegW-1:0]   seg_tens;
    logic [SegW-1:0]   seg_units;
    logic              point_position;
    logic              narrow_selected;
  } display_t;

  // One directed step: a register write or a sample, with an optional typed result.
  typedef struct packed {
    logic              is_write;
    avd_cfg_idx_e      reg_idx;
    logic [CountW-1:0] reg_data;
    logic [SampleW-1:0] smp;
    logic              typed;
    logic [CountW-1:0] want_reading;
    logic              want_narrow;
  } dir_row_t;

  localparam int NUM_ROWS = 24;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = '0;
  logic [CountW-1:0]  cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [SampleW-1:0] sample_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [CountW-1:0]  reading_o;
  logic [SegW-1:0]    seg_thousands_o;
  logic [SegW-1:0]    seg_hundreds_o;
  logic [SegW-1:0]    seg_tens_o;
  logic [SegW-1:0]    seg_units_o;
  logic               point_position_o;
  logic               narrow_selected_o;

  // Mirror of the block's registers and range flag.
  logic [SampleW-1:0] thr_low = 8'd6;
  logic [SampleW-1:0] thr_high = 8'd254;
  logic [CountW-1:0]  fs_wide = 14'd1000;
  logic [CountW-1:0]  fs_narrow = 14'd5000;
  logic               narrow_now = 1'b0;

  display_t    pending_displays [$];
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned hold_len = 0;
  int unsigned hold_seq = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  const dir_row_t dir_rows [NUM_ROWS] = '{
    '{1'b0, CFG_LOW_THRESHOLD,     14'd0,      8'd255, 1'b1, 14'd1000, 1'b0},
    '{1'b0, CFG_LOW_THRESHOLD,     14'd0,      8'd6,   1'b0, 14'd0,    1'b0},
    '{1'b0, CFG_LOW_THRESHOLD,     14'd0,      8'd5,   1'b0, 14'd0,    1'b0},
    '{1'b0, CFG_LOW_THRESHOLD,     14'd0,      8'd0,   1'b1, 14'd0,    1'b1},
    '{1'b0, CFG_LOW_THRESHOLD,     14'd0,      8'd254, 1'b0, 14'd0,    1'b0},
    '{1'b0, CFG_LOW_THRESHOLD,     14'd0,      8'd255, 1'b1, 14'd1000, 1'b0},
    '{1'b1, CFG_WIDE_FULL_SCALE,   14'h3fff,   8'd0,   1'b0, 14'd0,    1'b0},
    '{1'b0, CFG_LOW_THRESHOLD,     14'd0,      8'd255, 1'b1, 14'd9999, 1'b0},
    '{1'b0, CFG_LOW_THRESHOLD,     14'd0,      8'd128, 1'b0, 14'd0,    1'b0},
    '{1'b1, CFG_NARROW_FULL_SCALE, 14'd0,      8'd0,   1'b0, 14'd0,    1'b0},
    '{1'b1, CFG_LOW_THRESHOLD,     14'h3fff,   8'd0,   1'b0, 14'd0,    1'b0},
    '{1'b0, CFG_LOW_THRESHOLD,     14'd0,      8'd254, 1'b1, 14'd0,    1'b1},
    '{1'b0, CFG_LOW_THRESHOLD,     14'd0,      8'd255, 1'b1, 14'd9999, 1'b0},
    '{1'b1, CFG_LOW_THRESHOLD,     14'd0,      8'd0,   1'b0, 14'd0,    1'b0},
    '{1'b0, CFG_LOW_THRESHOLD,     14'd0,      8'd0,   1'b1, 14'd0,    1'b0},
    '{1'b1, CFG_LOW_THRESHOLD,     14'h00ff,   8'd0,   1'b0, 14'd0,    1'b0},
    '{1'b1, CFG_HIGH_THRESHOLD,    14'h3fff,   8'd0,   1'b0, 14'd0,    1'b0},
    '{1'b0, CFG_LOW_THRESHOLD,     14'd0,      8'd0,   1'b1, 14'd0,    1'b1},
    '{1'b0, CFG_LOW_THRESHOLD,     14'd0,      8'd255, 1'b1, 14'd0,    1'b1},
    '{1'b1, CFG_NARROW_FULL_SCALE, 14'd9999,   8'd0,   1'b0, 14'd0,    1'b0},
    '{1'b0, CFG_LOW_THRESHOLD,     14'd0,      8'd255, 1'b1, 14'd9999, 1'b1},
    '{1'b1, CFG_HIGH_THRESHOLD,    14'd0,      8'd0,   1'b0, 14'd0,    1'b0},
    '{1'b0, CFG_LOW_THRESHOLD,     14'd0,      8'd1,   1'b0, 14'd0,    1'b0},
    '{1'b0, CFG_LOW_THRESHOLD,     14'd0,      8'd0,   1'b1, 14'd0,    1'b1}
  };

  autorange_voltmeter_display_core i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .sample_i          (sample_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .reading_o         (reading_o),
    .seg_thousands_o   (seg_thousands_o),
    .seg_hundreds_o    (seg_hundreds_o),
    .seg_tens_o        (seg_tens_o),
    .seg_units_o       (seg_units_o),
    .point_position_o  (point_position_o),
    .narrow_selected_o (narrow_selected_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic display_t encode_display(input int unsigned rd, input logic narrow);
    display_t d;
    d.reading         = rd[CountW-1:0];
    d.seg_thousands   = DIGIT_SEGS[4'(rd / 1000)];
    d.seg_hundreds    = DIGIT_SEGS[4'((rd / 100) % 10)];
    d.seg_tens        = DIGIT_SEGS[4'((rd / 10) % 10)];
    d.seg_units       = DIGIT_SEGS[4'(rd % 10)];
    d.point_position  = narrow;
    d.narrow_selected = narrow;
    return d;
  endfunction

  // Range decision first, then scaling with the full scale of the new range.
  function automatic display_t predict_display(input logic [SampleW-1:0] s);
    int unsigned scaled;
    if (!narrow_now) begin
      if (s < thr_low) narrow_now = 1'b1;
    end else begin
      if (s > thr_high) narrow_now = 1'b0;
    end
    scaled = (int'(s) * int'(narrow_now ? fs_narrow : fs_wide)) / 255;
    if (scaled > 9999) scaled = 9999;
    return encode_display(scaled, narrow_now);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got, want);
    err_cnt++;
  endtask

  task automatic check_display();
    display_t want;
    if (pending_displays.size() == 0) begin
      report_mismatch("result item with none expected, reading", int'(reading_o), 0);
      return;
    end
    want = pending_displays.pop_front();
    if (reading_o != want.reading)
      report_mismatch("reading", int'(reading_o), int'(want.reading));
    if (seg_thousands_o != want.seg_thousands)
      report_mismatch("seg_thousands", int'(seg_thousands_o), int'(want.seg_thousands));
    if (seg_hundreds_o != want.seg_hundreds)
      report_mismatch("seg_hundreds", int'(seg_hundreds_o), int'(want.seg_hundreds));
    if (seg_tens_o != want.seg_tens)
      report_mismatch("seg_tens", int'(seg_tens_o), int'(want.seg_tens));
    if (seg_units_o != want.seg_units)
      report_mismatch("seg_units", int'(seg_units_o), int'(want.seg_units));
    if (point_position_o != want.point_position)
      report_mismatch("point_position", int'(point_position_o), int'(want.point_position));
    if (narrow_selected_o != want.narrow_selected)
      report_mismatch("narrow_selected", int'(narrow_selected_o),
                      int'(want.narrow_selected));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_display();
  end

  // Receiver: a requested hold-off wins over the random stall pattern.
  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen   <= hold_seq;
      hold_left   <= hold_len;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout with %0d result items outstanding", pending_displays.size());
      $display("[autorange_voltmeter_display_core] ERROR");
      $finish;
    end
  end

  task automatic write_reg(input avd_cfg_idx_e idx, input logic [CountW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      CFG_LOW_THRESHOLD:     thr_low = data[SampleW-1:0];
      CFG_HIGH_THRESHOLD:    thr_high = data[SampleW-1:0];
      CFG_WIDE_FULL_SCALE:   fs_wide = data;
      CFG_NARROW_FULL_SCALE: fs_narrow = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // The expectation is queued when the item is offered; items stay in order.
  task automatic send_sample(input logic [SampleW-1:0] s, input logic typed,
                             input display_t typed_display);
    display_t d;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    d = predict_display(s);
    pending_displays.push_back(typed ? typed_display : d);
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_displays.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [CountW-1:0] pick_threshold();
    case ($urandom_range(7))
      0:       return 14'd0;
      1:       return 14'd255;
      default: return 14'($urandom_range(16383));
    endcase
  endfunction

  function automatic logic [CountW-1:0] pick_full_scale();
    case ($urandom_range(7))
      0:       return 14'd0;
      1:       return 14'h3fff;
      2:       return 14'd9999;
      3:       return 14'($urandom_range(16383));
      default: return 14'($urandom_range(9999, 1));
    endcase
  endfunction

  // Samples cluster around the thresholds so the range flips often.
  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return thr_low - 8'd1;
      3:       return thr_low;
      4:       return thr_high;
      5:       return thr_high + 8'd1;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input int unsigned hold_cycles);
    wait_idle();
    write_reg(CFG_LOW_THRESHOLD, pick_threshold());
    write_reg(CFG_HIGH_THRESHOLD, pick_threshold());
    write_reg(CFG_WIDE_FULL_SCALE, pick_full_scale());
    write_reg(CFG_NARROW_FULL_SCALE, pick_full_scale());
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (hold_cycles != 0) begin
      hold_len <= hold_cycles;
      hold_seq <= hold_seq + 1;
    end
    repeat (ITEMS_PER_PHASE) send_sample(pick_sample(), 1'b0, '0);
  endtask

  initial begin
    dir_row_t row;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_write) begin
        wait_idle();
        write_reg(row.reg_idx, row.reg_data);
      end else begin
        send_sample(row.smp, row.typed,
                    encode_display(32'(row.want_reading), row.want_narrow));
      end
    end

    run_phase(0, 0, 0);
    run_phase(82, 0, 0);
    run_phase(0, 82, 0);
    run_phase(37, 37, 0);
    run_phase(0, 0, 400);

    wait_idle();
    if (err_cnt == 0) begin
      $display("[autorange_voltmeter_display_core] OK");
    end else begin
      $display("[autorange_voltmeter_display_core] ERROR");
    end
    $finish;
  end

endmodule

// File: autorange_voltmeter_display_core.f
+incdir+sv
sv/avd_pkg.sv
sv/avd_queue.sv
sv/avd_front.sv
sv/avd_back.sv
sv/autorange_voltmeter_display_core.sv
sv/avd_checker.sv
tb/tb_autorange_voltmeter_display_core.sv
